[sv/alt_pkg.sv]
// Shared types, codes and character helpers for the assembly line tokenizer.
package alt_pkg;

    // Scanner modes.
    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_TEXT    = 3'd2,
        M_NUMBER  = 3'd3,
        M_CHVAL   = 3'd4,
        M_CHCLOSE = 3'd5,
        M_ADDR    = 3'd6,
        M_STRING  = 3'd7
    } mode_t;

    // Result record kinds.
    localparam logic [1:0] R_TEXT_CHAR = 2'd0;
    localparam logic [1:0] R_TOKEN_END = 2'd1;
    localparam logic [1:0] R_LINE_END  = 2'd2;

    // Token kinds.
    localparam logic [2:0] TK_TEXT    = 3'd0;
    localparam logic [2:0] TK_LABEL   = 3'd1;
    localparam logic [2:0] TK_PREPROC = 3'd2;
    localparam logic [2:0] TK_NUMBER  = 3'd3;
    localparam logic [2:0] TK_ADDRESS = 3'd4;
    localparam logic [2:0] TK_STRING  = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    // Result queue depth, in items.
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  text_char;
        logic [2:0]  token_kind;
        logic [7:0]  token_length;
        logic [31:0] number_value;
        logic [7:0]  tokens_in_line;
        logic [31:0] line_number;
        logic        length_overflow;
    } result_t;

    // Everything one input item produces.
    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    two;
    } bundle_t;

    function automatic logic is_text_char(input logic [7:0] c);
        return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)
            || c == CH_DOT || c == CH_UNDER;
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic result_t mk_char(input logic [7:0] c, input logic [2:0] tk);
        result_t r;
        r = '0;
        r.kind       = R_TEXT_CHAR;
        r.text_char  = c;
        r.token_kind = tk;
        return r;
    endfunction

    function automatic result_t mk_end(input logic [2:0] tk, input logic [7:0] len,
                                       input logic [31:0] acc, input logic ovf);
        result_t r;
        r = '0;
        r.kind            = R_TOKEN_END;
        r.token_kind      = tk;
        r.token_length    = len;
        r.number_value    = (tk == TK_NUMBER) ? acc : 32'd0;
        r.length_overflow = ovf;
        return r;
    endfunction

    function automatic result_t mk_line(input logic [7:0] cnt, input logic [31:0] line);
        result_t r;
        r = '0;
        r.kind           = R_LINE_END;
        r.tokens_in_line = cnt;
        r.line_number    = line;
        return r;
    endfunction

endpackage

[sv/assembly_line_tokenizer.sv]
// Top level of the assembly line tokenizer: scanner plus result queue.
// Results of an item are registered in the result queue before they reach the output.
// Throughput: one char per cycle while in_stall is low; an item with two results holds the output for both in turn.
// The two-entry result queue sets stall; it is raised only while both entries are held.
// Reset (async, active low) returns the scanner to idle, clears the line counter,
// token count and empties the result queue.
module assembly_line_tokenizer #(
    parameter int MAX_TOKEN_LEN   = 255,
    parameter int MAX_LINE_TOKENS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  text_char,
    output logic [2:0]  token_kind,
    output logic [7:0]  token_length,
    output logic [31:0] number_value,
    output logic [7:0]  tokens_in_line,
    output logic [31:0] line_number,
    output logic        length_overflow,
    output logic        last
);
    import alt_pkg::*;

    localparam logic [7:0] LEN_LIMIT =
        (MAX_TOKEN_LEN > 255) ? 8'd255 : 8'(MAX_TOKEN_LEN);
    localparam logic [7:0] CNT_LIMIT =
        (MAX_LINE_TOKENS > 255) ? 8'd255 : 8'(MAX_LINE_TOKENS);

    logic    fire;
    logic    push;
    logic    full;
    bundle_t push_bundle;
    result_t out_res;

    assign in_stall = full;
    assign fire     = in_valid && !full;

    alt_scan #(
        .LEN_LIMIT (LEN_LIMIT),
        .CNT_LIMIT (CNT_LIMIT)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .ch          (ch),
        .push        (push),
        .push_bundle (push_bundle)
    );

    alt_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_res     (out_res),
        .out_last    (last)
    );

    assign kind            = out_res.kind;
    assign text_char       = out_res.text_char;
    assign token_kind      = out_res.token_kind;
    assign token_length    = out_res.token_length;
    assign number_value    = out_res.number_value;
    assign tokens_in_line  = out_res.tokens_in_line;
    assign line_number     = out_res.line_number;
    assign length_overflow = out_res.length_overflow;

endmodule

[sv/alt_scan.sv]
// Scanner: mode state and the single-pass step that yields up to two results.
module alt_scan #(
    parameter logic [7:0] LEN_LIMIT = 8'd255,
    parameter logic [7:0] CNT_LIMIT = 8'd255
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      ch,
    output logic            push,
    output alt_pkg::bundle_t push_bundle
);
    import alt_pkg::*;

    mode_t       mode_reg, mode_next;
    logic        esc_reg, esc_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [31:0] line_reg, line_next;
    logic        ovf_reg, ovf_next;

    result_t     res_v [2];
    logic [1:0]  n_v;
    logic        again;
    logic        eol;
    logic [7:0]  mapped;
    logic [31:0] digit;

    assign eol   = (ch == CH_NL) || (ch == CH_NUL);
    assign digit = {24'd0, ch - CH_ZERO};

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        kind_next = kind_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        ovf_next  = ovf_reg;
        res_v[0]  = '0;
        res_v[1]  = '0;
        n_v       = 2'd0;
        again     = 1'b0;
        mapped    = ch;

        unique case (mode_reg)
            M_COMMENT:
            begin
                if (eol)
                begin
                    line_next = line_next + 32'd1;
                    res_v[n_v[0]] = mk_line(cnt_next, line_next);
                    n_v = n_v + 2'd1;
                    cnt_next  = 8'd0;
                    mode_next = M_IDLE;
                    esc_next  = 1'b0;
                end
            end
            M_TEXT:
            begin
                if (is_text_char(ch))
                begin
                    if (len_next < LEN_LIMIT)
                    begin
                        res_v[n_v[0]] = mk_char(ch, kind_next);
                        n_v = n_v + 2'd1;
                        len_next = len_next + 8'd1;
                    end
                    else
                        ovf_next = 1'b1;
                end
                else
                begin
                    if (ch == CH_COLON)
                        kind_next = TK_LABEL;
                    else
                        again = 1'b1;
                    res_v[n_v[0]] = mk_end(kind_next, len_next, acc_next, ovf_next);
                    n_v = n_v + 2'd1;
                    if (cnt_next < CNT_LIMIT)
                        cnt_next = cnt_next + 8'd1;
                    mode_next = M_IDLE;
                    esc_next  = 1'b0;
                end
            end
            M_NUMBER:
            begin
                if (is_digit_char(ch))
                    acc_next = (acc_next << 3) + (acc_next << 1) + digit;
                else
                begin
                    res_v[n_v[0]] = mk_end(kind_next, len_next, acc_next, ovf_next);
                    n_v = n_v + 2'd1;
                    if (cnt_next < CNT_LIMIT)
                        cnt_next = cnt_next + 8'd1;
                    mode_next = M_IDLE;
                    esc_next  = 1'b0;
                    again     = 1'b1;
                end
            end
            M_CHVAL:
            begin
                // a line end here leaves the value at zero and is rescanned
                if (!eol)
                    acc_next = {24'd0, ch};
                res_v[n_v[0]] = mk_end(kind_next, len_next, acc_next, ovf_next);
                n_v = n_v + 2'd1;
                if (cnt_next < CNT_LIMIT)
                    cnt_next = cnt_next + 8'd1;
                esc_next = 1'b0;
                if (eol)
                begin
                    mode_next = M_IDLE;
                    again     = 1'b1;
                end
                else
                    mode_next = M_CHCLOSE;
            end
            M_CHCLOSE:
            begin
                if (eol)
                    again = 1'b1;
                else
                    mode_next = M_IDLE;
            end
            M_ADDR, M_STRING:
            begin
                if (eol || (mode_reg == M_ADDR && ch == CH_RBRACK)
                    || (mode_reg == M_STRING && !esc_reg && ch == CH_DQUOTE))
                begin
                    res_v[n_v[0]] = mk_end(kind_next, len_next, acc_next, ovf_next);
                    n_v = n_v + 2'd1;
                    if (cnt_next < CNT_LIMIT)
                        cnt_next = cnt_next + 8'd1;
                    mode_next = M_IDLE;
                    esc_next  = 1'b0;
                    again     = eol;
                end
                else if (mode_reg == M_STRING && !esc_reg && ch == CH_BSLASH)
                    esc_next = 1'b1;
                else
                begin
                    if (mode_reg == M_STRING && esc_reg)
                    begin
                        priority if (ch == CH_LC_N)
                            mapped = CH_NL;
                        else if (ch == CH_LC_T)
                            mapped = CH_TAB;
                        else if (ch == CH_ZERO)
                            mapped = CH_NUL;
                        else
                            mapped = ch;
                        esc_next = 1'b0;
                    end
                    if (len_next < LEN_LIMIT)
                    begin
                        res_v[n_v[0]] = mk_char(mapped, kind_next);
                        n_v = n_v + 2'd1;
                        len_next = len_next + 8'd1;
                    end
                    else
                        ovf_next = 1'b1;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                again     = 1'b1;
            end
        endcase

        // between-token handling, also for the char that ended a token
        if (again)
        begin
            priority if (eol)
            begin
                line_next = line_next + 32'd1;
                res_v[n_v[0]] = mk_line(cnt_next, line_next);
                n_v = n_v + 2'd1;
                cnt_next  = 8'd0;
                mode_next = M_IDLE;
                esc_next  = 1'b0;
            end
            else if (ch == CH_SEMI)
                mode_next = M_COMMENT;
            else if (is_text_char(ch) || ch == CH_HASH || is_digit_char(ch)
                     || ch == CH_SQUOTE || ch == CH_LBRACK || ch == CH_DQUOTE)
            begin
                len_next = 8'd0;
                acc_next = 32'd0;
                ovf_next = 1'b0;
                esc_next = 1'b0;
                priority if (is_text_char(ch))
                begin
                    mode_next = M_TEXT;
                    kind_next = TK_TEXT;
                    if (len_next < LEN_LIMIT)
                    begin
                        res_v[n_v[0]] = mk_char(ch, kind_next);
                        n_v = n_v + 2'd1;
                        len_next = len_next + 8'd1;
                    end
                    else
                        ovf_next = 1'b1;
                end
                else if (ch == CH_HASH)
                begin
                    mode_next = M_TEXT;
                    kind_next = TK_PREPROC;
                end
                else if (is_digit_char(ch))
                begin
                    mode_next = M_NUMBER;
                    kind_next = TK_NUMBER;
                    acc_next  = digit;
                end
                else if (ch == CH_SQUOTE)
                begin
                    mode_next = M_CHVAL;
                    kind_next = TK_NUMBER;
                end
                else if (ch == CH_LBRACK)
                begin
                    mode_next = M_ADDR;
                    kind_next = TK_ADDRESS;
                end
                else
                begin
                    mode_next = M_STRING;
                    kind_next = TK_STRING;
                end
            end
            else
                mode_next = mode_next;  // blanks, tabs, unknown chars
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            esc_reg  <= 1'b0;
            kind_reg <= TK_TEXT;
            len_reg  <= 8'd0;
            acc_reg  <= 32'd0;
            cnt_reg  <= 8'd0;
            line_reg <= 32'd0;
            ovf_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            kind_reg <= kind_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign push            = fire && (n_v != 2'd0);
    assign push_bundle.r0  = res_v[0];
    assign push_bundle.r1  = res_v[1];
    assign push_bundle.two = n_v[1];

    a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> mode_reg == M_STRING)
        else $error("escape pending outside a string");

    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_bundle.two) |-> push_bundle.r0.kind != R_LINE_END)
        else $error("line end record not last of its item");

endmodule

[sv/alt_outq.sv]
// Result queue: holds per-item result pairs and hands them out one at a time.
module alt_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  alt_pkg::bundle_t push_bundle,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output alt_pkg::result_t out_res,
    output logic             out_last
);
    import alt_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    bundle_t         bundle_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            sub_reg, sub_next;
    bundle_t         head;
    logic            out_fire;
    logic            pop;

    assign head      = bundle_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign full      = (count_reg == CW'(Q_DEPTH));
    assign out_res   = sub_reg ? head.r1 : head.r0;
    assign out_last  = sub_reg || !head.two;
    assign out_fire  = out_valid && !out_stall;
    assign pop       = out_fire && out_last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
        if (out_fire)
            sub_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            bundle_reg[wr_ptr_reg] <= push_bundle;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(Q_DEPTH))
        else $error("result queue count past depth");

    a_sub_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (out_valid && head.two))
        else $error("second result selected for a single-result item");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full result queue");

endmodule

[tb/alt_token_checker.sv]
// Checker for the assembly line tokenizer: tracks scanner state, predicts records, compares.
module alt_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  text_char,
    input  logic [2:0]  token_kind,
    input  logic [7:0]  token_length,
    input  logic [31:0] number_value,
    input  logic [7:0]  tokens_in_line,
    input  logic [31:0] line_number,
    input  logic        length_overflow,
    input  logic        last,
    output int          fails,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import alt_pkg::*;

    localparam logic [7:0] LEN_CAP   = 8'd255;
    localparam logic [7:0] COUNT_CAP = 8'd255;

    typedef struct packed {
        result_t rec;
        logic    last;
    } token_rec_t;

    // predicted scanner state
    mode_t       scan_mode;
    logic        esc_pending;
    logic [2:0]  tok_kind;
    logic [7:0]  tok_len;
    logic [31:0] acc;
    logic [7:0]  line_tokens;
    logic [31:0] line_count;
    logic        tok_overflow;

    token_rec_t expected_records[$];
    token_rec_t step_buf[2];
    int         step_n;
    token_rec_t want;

    function automatic logic text_byte(input logic [7:0] c);
        return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)
            || c == CH_DOT || c == CH_UNDER;
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void emit(input logic [1:0] k, input logic [7:0] tc,
                                 input logic [2:0] tk, input logic [7:0] tl,
                                 input logic [31:0] v, input logic [7:0] tin,
                                 input logic [31:0] ln, input logic ovf);
        token_rec_t r;
        r = '0;
        r.rec.kind            = k;
        r.rec.text_char       = tc;
        r.rec.token_kind      = tk;
        r.rec.token_length    = tl;
        r.rec.number_value    = v;
        r.rec.tokens_in_line  = tin;
        r.rec.line_number     = ln;
        r.rec.length_overflow = ovf;
        step_buf[step_n] = r;
        step_n++;
    endfunction

    function automatic void begin_token(input mode_t m, input logic [2:0] k);
        scan_mode    = m;
        tok_kind     = k;
        tok_len      = 8'd0;
        acc          = 32'd0;
        tok_overflow = 1'b0;
        esc_pending  = 1'b0;
    endfunction

    // chars past the cap are dropped silently and only flag the token
    function automatic void append_text(input logic [7:0] c);
        if (tok_len < LEN_CAP)
        begin
            emit(R_TEXT_CHAR, c, tok_kind, 8'd0, 32'd0, 8'd0, 32'd0, 1'b0);
            tok_len++;
        end
        else
            tok_overflow = 1'b1;
    endfunction

    function automatic void finish_token();
        emit(R_TOKEN_END, 8'd0, tok_kind, tok_len, (tok_kind == TK_NUMBER) ? acc : 32'd0,
             8'd0, 32'd0, tok_overflow);
        if (line_tokens < COUNT_CAP)
            line_tokens++;
        scan_mode   = M_IDLE;
        esc_pending = 1'b0;
    endfunction

    function automatic void finish_line();
        line_count++;
        emit(R_LINE_END, 8'd0, TK_TEXT, 8'd0, 32'd0, line_tokens, line_count, 1'b0);
        line_tokens = 8'd0;
        scan_mode   = M_IDLE;
        esc_pending = 1'b0;
    endfunction

    // Predicts the records caused by one input char and queues them.
    function automatic void tokenize_char(input logic [7:0] c);
        logic       eol;
        logic       again;
        logic [7:0] m;
        eol   = (c == CH_NL) || (c == CH_NUL);
        again = 1'b0;
        step_n = 0;
        case (scan_mode)
            M_COMMENT:
                if (eol)
                    finish_line();
            M_TEXT:
            begin
                if (text_byte(c))
                    append_text(c);
                else if (c == CH_COLON)
                begin
                    tok_kind = TK_LABEL;
                    finish_token();
                end
                else
                begin
                    finish_token();
                    again = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (digit_byte(c))
                    acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
                else
                begin
                    finish_token();
                    again = 1'b1;
                end
            end
            M_CHVAL:
            begin
                if (eol)
                begin
                    finish_token();
                    again = 1'b1;
                end
                else
                begin
                    acc = {24'd0, c};
                    finish_token();
                    scan_mode = M_CHCLOSE;
                end
            end
            M_CHCLOSE:
            begin
                // closing quote slot: anything but a line end is swallowed
                if (eol)
                    again = 1'b1;
                else
                    scan_mode = M_IDLE;
            end
            M_ADDR:
            begin
                if (eol)
                begin
                    finish_token();
                    again = 1'b1;
                end
                else if (c == CH_RBRACK)
                    finish_token();
                else
                    append_text(c);
            end
            M_STRING:
            begin
                if (eol)
                begin
                    finish_token();
                    again = 1'b1;
                end
                else if (esc_pending)
                begin
                    m = c;
                    if (c == CH_LC_N)
                        m = CH_NL;
                    else if (c == CH_LC_T)
                        m = CH_TAB;
                    else if (c == CH_ZERO)
                        m = CH_NUL;
                    esc_pending = 1'b0;
                    append_text(m);
                end
                else if (c == CH_BSLASH)
                    esc_pending = 1'b1;
                else if (c == CH_DQUOTE)
                    finish_token();
                else
                    append_text(c);
            end
            default:
            begin
                scan_mode = M_IDLE;
                again     = 1'b1;
            end
        endcase

        // char seen between tokens
        if (again)
        begin
            if (eol)
                finish_line();
            else if (c == CH_SEMI)
                scan_mode = M_COMMENT;
            else if (text_byte(c))
            begin
                begin_token(M_TEXT, TK_TEXT);
                append_text(c);
            end
            else if (c == CH_HASH)
                begin_token(M_TEXT, TK_PREPROC);
            else if (digit_byte(c))
            begin
                begin_token(M_NUMBER, TK_NUMBER);
                acc = {24'd0, c - CH_ZERO};
            end
            else if (c == CH_SQUOTE)
                begin_token(M_CHVAL, TK_NUMBER);
            else if (c == CH_LBRACK)
                begin_token(M_ADDR, TK_ADDRESS);
            else if (c == CH_DQUOTE)
                begin_token(M_STRING, TK_STRING);
        end

        if (step_n > 0)
            step_buf[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_records.push_back(step_buf[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode    = M_IDLE;
            esc_pending  = 1'b0;
            tok_kind     = TK_TEXT;
            tok_len      = 8'd0;
            acc          = 32'd0;
            line_tokens  = 8'd0;
            line_count   = 32'd0;
            tok_overflow = 1'b0;
            expected_records.delete();
            fails = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("record with nothing expected: kind %0d", kind);
                    fails++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("kind", 32'(want.rec.kind), 32'(kind));
                    check_field("text_char", 32'(want.rec.text_char), 32'(text_char));
                    check_field("token_kind", 32'(want.rec.token_kind), 32'(token_kind));
                    check_field("token_length", 32'(want.rec.token_length),
                                32'(token_length));
                    check_field("number_value", want.rec.number_value, number_value);
                    check_field("tokens_in_line", 32'(want.rec.tokens_in_line),
                                32'(tokens_in_line));
                    check_field("line_number", want.rec.line_number, line_number);
                    check_field("length_overflow", 32'(want.rec.length_overflow),
                                32'(length_overflow));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (in_valid && !in_stall)
                tokenize_char(ch);
            outstanding <= expected_records.size();
        end
    end

endmodule

[tb/assembly_line_tokenizer_test.sv]
// Testbench top for the assembly line tokenizer: clock, reset, source text stimulus, verdict.
module assembly_line_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import alt_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  ch        = 8'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  kind;
    logic [7:0]  text_char;
    logic [2:0]  token_kind;
    logic [7:0]  token_length;
    logic [31:0] number_value;
    logic [7:0]  tokens_in_line;
    logic [31:0] line_number;
    logic        length_overflow;
    logic        last;
    int          fails;
    int          outstanding;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    assembly_line_tokenizer DUT (.*);

    alt_token_checker checker_i (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] pick_text_char();
        int p;
        p = $urandom_range(9);
        if (p < 4)
            return 8'(CH_UC_A + $urandom_range(25));
        else if (p < 8)
            return 8'(CH_LC_A + $urandom_range(25));
        else if (p == 8)
            return CH_DOT;
        else
            return CH_UNDER;
    endfunction

    // any byte that does not end the line
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_NL || b == CH_NUL)
            b = 8'($urandom_range(1, 9));
        return b;
    endfunction

    // valid stays high across back-to-back items; lowered only for a gap
    task automatic send_char(input logic [7:0] c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] directed[$];
        logic [7:0] line_chars[$];
        logic [7:0] b;
        int         phase;
        int         sent;
        int         len;
        int         pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // label, preproc, number ended by an unknown byte, char literal with a
        // swallowed close, address, string with escapes closed by line end,
        // char literal cut by NUL, comment with a high byte
        directed = '{CH_UNDER, CH_UC_Z, CH_COLON, " ", CH_HASH, "q", CH_TAB, CH_ZERO,
                     8'hFF, CH_SQUOTE, 8'hFF, "x", CH_LBRACK, "a", CH_RBRACK, CH_DQUOTE,
                     CH_BSLASH, CH_LC_N, CH_BSLASH, "q", CH_NL, CH_SQUOTE, CH_NUL,
                     CH_SEMI, 8'h80, CH_NL};
        foreach (directed[i])
            send_char(directed[i]);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 64;
                end
                default:
                begin
                    send_idle_pct = 34;
                    recv_stall_pct <= 34;
                end
            endcase

            sent = 0;
            while (sent < 460)
            begin
                line_chars.delete();

                // one oversize case per phase: long token, or a line full of tokens
                if (sent == 0)
                begin
                    if (phase == 0 || phase == 3)
                    begin
                        len = $urandom_range(250, 275);
                        if (phase == 3)
                            line_chars.push_back(CH_DQUOTE);
                        repeat (len)
                        begin
                            if (phase == 3)
                            begin
                                b = plain_byte();
                                if (b == CH_DQUOTE || b == CH_BSLASH)
                                    b = "s";
                                line_chars.push_back(b);
                            end
                            else
                                line_chars.push_back(pick_text_char());
                        end
                        line_chars.push_back((phase == 3) ? CH_DQUOTE : CH_COLON);
                    end
                    else
                    begin
                        len = $urandom_range(330, 360);
                        repeat (len)
                            line_chars.push_back(($urandom_range(7) == 0)
                                ? 8'(CH_ZERO + $urandom_range(9)) : CH_HASH);
                    end
                end

                repeat ($urandom_range(0, 7))
                begin
                    pick = $urandom_range(99);
                    if (pick < 30)
                    begin
                        if ($urandom_range(3) == 0)
                            line_chars.push_back(CH_HASH);
                        repeat ($urandom_range(1, 6))
                            line_chars.push_back(pick_text_char());
                        if ($urandom_range(3) == 0)
                            line_chars.push_back(CH_COLON);
                    end
                    else if (pick < 50)
                    begin
                        // long digit runs wrap the value
                        len = ($urandom_range(9) == 0) ? $urandom_range(10, 14)
                                                       : $urandom_range(1, 3);
                        repeat (len)
                            line_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
                    end
                    else if (pick < 60)
                    begin
                        line_chars.push_back(CH_SQUOTE);
                        line_chars.push_back(8'($urandom_range(255)));
                        line_chars.push_back(($urandom_range(3) == 0)
                            ? 8'($urandom_range(255)) : CH_SQUOTE);
                    end
                    else if (pick < 72)
                    begin
                        line_chars.push_back(CH_LBRACK);
                        repeat ($urandom_range(0, 6))
                        begin
                            b = plain_byte();
                            if (b == CH_RBRACK)
                                b = "r";
                            line_chars.push_back(b);
                        end
                        if ($urandom_range(4) != 0)
                            line_chars.push_back(CH_RBRACK);
                    end
                    else if (pick < 90)
                    begin
                        line_chars.push_back(CH_DQUOTE);
                        repeat ($urandom_range(0, 6))
                        begin
                            if ($urandom_range(3) == 0)
                            begin
                                line_chars.push_back(CH_BSLASH);
                                case ($urandom_range(4))
                                    0: b = CH_LC_N;
                                    1: b = CH_LC_T;
                                    2: b = CH_ZERO;
                                    3: b = CH_DQUOTE;
                                    default: b = plain_byte();
                                endcase
                            end
                            else
                            begin
                                b = plain_byte();
                                if (b == CH_DQUOTE || b == CH_BSLASH)
                                    b = "s";
                            end
                            line_chars.push_back(b);
                        end
                        if ($urandom_range(4) != 0)
                            line_chars.push_back(CH_DQUOTE);
                    end
                    else
                        line_chars.push_back(8'($urandom_range(255)));

                    pick = $urandom_range(9);
                    if (pick > 0)
                        line_chars.push_back((pick < 7) ? 8'(" ") : CH_TAB);
                end

                if ($urandom_range(4) == 0)
                begin
                    line_chars.push_back(CH_SEMI);
                    repeat ($urandom_range(0, 5))
                        line_chars.push_back(plain_byte());
                end
                line_chars.push_back(($urandom_range(9) == 0) ? CH_NUL : CH_NL);

                sent += line_chars.size();
                foreach (line_chars[i])
                    send_char(line_chars[i]);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
sv/alt_pkg.sv
sv/alt_scan.sv
sv/alt_outq.sv
sv/assembly_line_tokenizer.sv
tb/alt_token_checker.sv
tb/assembly_line_tokenizer_test.sv
